// ===== hdl/xmr_pkg.sv =====
// Shared types and constants of the xorshift / congruential generator.
`timescale 1ns / 1ps

package xmr_pkg;

    typedef enum logic [1:0] {
        OP_LOAD     = 2'd0,
        OP_XORSHIFT = 2'd1,
        OP_LCG      = 2'd2,
        OP_BOTH     = 2'd3
    } opcode_t;

    localparam logic [2:0] REG_SHIFT_FIRST_LEFT  = 3'd0;
    localparam logic [2:0] REG_SHIFT_RIGHT       = 3'd1;
    localparam logic [2:0] REG_SHIFT_SECOND_LEFT = 3'd2;
    localparam logic [2:0] REG_MULTIPLIER        = 3'd3;
    localparam logic [2:0] REG_INCREMENT         = 3'd4;

    localparam logic [5:0]  RESET_SHIFT_FIRST_LEFT  = 6'd21;
    localparam logic [5:0]  RESET_SHIFT_RIGHT       = 6'd35;
    localparam logic [5:0]  RESET_SHIFT_SECOND_LEFT = 6'd4;
    localparam logic [63:0] RESET_MULTIPLIER        = 64'd2685821657736338717;
    localparam logic [63:0] RESET_INCREMENT         = 64'd0;
    localparam logic [63:0] RESET_STATE             = 64'd4101842887655102017;

    typedef struct packed {
        logic [5:0]  shift_first_left;
        logic [5:0]  shift_right;
        logic [5:0]  shift_second_left;
        logic [63:0] multiplier;
        logic [63:0] increment;
    } cfg_t;

endpackage

// ===== hdl/xmr_ifs.sv =====
// Request, response and configuration channel interfaces.
`timescale 1ns / 1ps

interface xmr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [63:0] seed_value;

    modport source (output valid, output opcode, output seed_value, input ready);
    modport sink (input valid, input opcode, input seed_value, output ready);
endinterface

interface xmr_rsp_if;
    logic        valid;
    logic        ready;
    logic [63:0] random_value;

    modport source (output valid, output random_value, input ready);
    modport sink (input valid, input random_value, output ready);
endinterface

interface xmr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [63:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hdl/xorshift_mlcg_random_generator.sv =====
// Top level of the xorshift / congruential random generator.
// An accepted request's response is registered and presented in the next cycle.
// Throughput: one request per cycle while no pending response is stalled; the state
// register feeds back combinationally through the xorshift shifters and the partial-product multiply-add.
// Reset: state loads its seed constant, registers take their defaults,
// no response is pending.
`timescale 1ns / 1ps

module xorshift_mlcg_random_generator (
    input  logic      clk,
    input  logic      rst_n,
    xmr_req_if.sink   req,
    xmr_rsp_if.source rsp,
    xmr_cfg_if.sink   cfg
);

    xmr_pkg::cfg_t    regs;
    xmr_pkg::opcode_t opcode;
    logic [63:0]      xs_value;
    logic [63:0]      lcg_in;
    logic [63:0]      lcg_value;
    logic [63:0]      state_reg;
    logic [63:0]      state_next;
    logic             valid_reg;
    logic             valid_next;
    logic             accept;

    xmr_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    xmr_xorshift u_xorshift (
        .state             (state_reg),
        .shift_first_left  (regs.shift_first_left),
        .shift_right       (regs.shift_right),
        .shift_second_left (regs.shift_second_left),
        .result            (xs_value)
    );

    assign opcode = xmr_pkg::opcode_t'(req.opcode);
    assign lcg_in = (opcode == xmr_pkg::OP_BOTH) ? xs_value : state_reg;

    xmr_lcg u_lcg (
        .state      (lcg_in),
        .multiplier (regs.multiplier),
        .increment  (regs.increment),
        .result     (lcg_value)
    );

    assign req.ready        = !valid_reg || rsp.ready;
    assign accept           = req.valid && req.ready;
    assign rsp.valid        = valid_reg;
    assign rsp.random_value = state_reg;

    always_comb
    begin
        state_next = state_reg;
        if (accept)
        begin
            unique case (opcode)
                xmr_pkg::OP_LOAD:     state_next = req.seed_value;
                xmr_pkg::OP_XORSHIFT: state_next = xs_value;
                xmr_pkg::OP_LCG:      state_next = lcg_value;
                xmr_pkg::OP_BOTH:     state_next = lcg_value;
                default:              state_next = state_reg;
            endcase
        end
    end

    always_comb
    begin
        priority if (accept)
            valid_next = 1'b1;
        else if (rsp.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= xmr_pkg::RESET_STATE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== hdl/xmr_cfg_regs.sv =====
// Configuration register file: shift amounts, multiplier and increment.
`timescale 1ns / 1ps

module xmr_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    xmr_cfg_if.sink     cfg,
    output xmr_pkg::cfg_t regs
);

    xmr_pkg::cfg_t regs_reg;
    xmr_pkg::cfg_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                xmr_pkg::REG_SHIFT_FIRST_LEFT:  regs_next.shift_first_left  = cfg.data[5:0];
                xmr_pkg::REG_SHIFT_RIGHT:       regs_next.shift_right       = cfg.data[5:0];
                xmr_pkg::REG_SHIFT_SECOND_LEFT: regs_next.shift_second_left = cfg.data[5:0];
                xmr_pkg::REG_MULTIPLIER:        regs_next.multiplier        = cfg.data;
                xmr_pkg::REG_INCREMENT:         regs_next.increment         = cfg.data;
                default:                        regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.shift_first_left  <= xmr_pkg::RESET_SHIFT_FIRST_LEFT;
            regs_reg.shift_right       <= xmr_pkg::RESET_SHIFT_RIGHT;
            regs_reg.shift_second_left <= xmr_pkg::RESET_SHIFT_SECOND_LEFT;
            regs_reg.multiplier        <= xmr_pkg::RESET_MULTIPLIER;
            regs_reg.increment         <= xmr_pkg::RESET_INCREMENT;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

// ===== hdl/xmr_xorshift.sv =====
// Three-stage shift-and-XOR step with programmable shift amounts.
`timescale 1ns / 1ps

module xmr_xorshift (
    input  logic [63:0] state,
    input  logic [5:0]  shift_first_left,
    input  logic [5:0]  shift_right,
    input  logic [5:0]  shift_second_left,
    output logic [63:0] result
);

    logic [63:0] stage1;
    logic [63:0] stage2;

    assign stage1 = state ^ (state << shift_first_left);
    assign stage2 = stage1 ^ (stage1 >> shift_right);
    assign result = stage2 ^ (stage2 << shift_second_left);

endmodule

// ===== hdl/xmr_lcg.sv =====
// Congruential step: wrapped multiply-add from 32-bit partial products, all-ones folded to zero.
`timescale 1ns / 1ps

module xmr_lcg (
    input  logic [63:0] state,
    input  logic [63:0] multiplier,
    input  logic [63:0] increment,
    output logic [63:0] result
);

    logic [31:0] a_lo;
    logic [31:0] a_hi;
    logic [31:0] b_lo;
    logic [31:0] b_hi;
    logic [63:0] prod_ll;
    logic [31:0] prod_lh;
    logic [31:0] prod_hl;
    logic [31:0] cross_sum;
    logic [63:0] sum;

    assign a_lo = state[31:0];
    assign a_hi = state[63:32];
    assign b_lo = multiplier[31:0];
    assign b_hi = multiplier[63:32];

    // only the low half of each cross product reaches the wrapped result
    assign prod_ll   = {32'd0, a_lo} * {32'd0, b_lo};
    assign prod_lh   = a_lo * b_hi;
    assign prod_hl   = a_hi * b_lo;
    assign cross_sum = prod_lh + prod_hl;

    assign sum    = prod_ll + {cross_sum, 32'd0} + increment;
    assign result = (sum == {64{1'b1}}) ? 64'd0 : sum;

endmodule

// ===== hdl/xmr_checker.sv =====
// Port-level assertions for the random generator, bound to the top level.
`timescale 1ns / 1ps

module xmr_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        req_valid,
    input logic        req_ready,
    input logic [1:0]  req_opcode,
    input logic [63:0] req_seed_value,
    input logic        rsp_valid,
    input logic        rsp_ready,
    input logic [63:0] rsp_random_value
);

    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> rsp_valid)
        else $error("accepted request gave no response");

    a_load_seed: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && req_opcode == 2'(xmr_pkg::OP_LOAD))
            |=> rsp_random_value == $past(req_seed_value))
        else $error("seed load not reflected in response");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("request stalled with no pending response");

    a_resp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_random_value)))
        else $error("stalled response changed");

endmodule

bind xorshift_mlcg_random_generator xmr_checker u_xmr_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .req_opcode       (req.opcode),
    .req_seed_value   (req.seed_value),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_random_value (rsp.random_value)
);

// ===== test/xmr_checker.sv =====
// Checker that predicts every generator response and compares it with the block output.
`timescale 1ns / 1ps

module xmr_scoreboard (
    input  logic clk,
    input  logic rst_n,
    xmr_req_if   req,
    xmr_rsp_if   rsp,
    xmr_cfg_if   cfg,
    output int   failures,
    output int   pending
);

    xmr_pkg::cfg_t settings;
    logic [63:0]   gen_state;
    logic [63:0]   expected_values[$];
    logic [63:0]   oldest;

    function automatic logic [63:0] xorshift_step(input logic [63:0] s);
        logic [63:0] t;
        t = s ^ (s << settings.shift_first_left);
        t = t ^ (t >> settings.shift_right);
        t = t ^ (t << settings.shift_second_left);
        return t;
    endfunction

    function automatic logic [63:0] congruential_step(input logic [63:0] s);
        logic [63:0] v;
        v = settings.multiplier * s + settings.increment;
        return (v == '1) ? '0 : v;
    endfunction

    function automatic logic [63:0] next_state(input xmr_pkg::opcode_t op,
                                               input logic [63:0] seed,
                                               input logic [63:0] s);
        logic [63:0] t;
        t = s;
        case (op)
            xmr_pkg::OP_LOAD:     t = seed;
            xmr_pkg::OP_XORSHIFT: t = xorshift_step(s);
            xmr_pkg::OP_LCG:      t = congruential_step(s);
            xmr_pkg::OP_BOTH:     t = congruential_step(xorshift_step(s));
            default:              t = 'x;
        endcase
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("ERROR at %0t: %s: got %h, expected %h", $time, what, got, want);
        failures++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settings.shift_first_left  = xmr_pkg::RESET_SHIFT_FIRST_LEFT;
            settings.shift_right       = xmr_pkg::RESET_SHIFT_RIGHT;
            settings.shift_second_left = xmr_pkg::RESET_SHIFT_SECOND_LEFT;
            settings.multiplier        = xmr_pkg::RESET_MULTIPLIER;
            settings.increment         = xmr_pkg::RESET_INCREMENT;
            gen_state = xmr_pkg::RESET_STATE;
            expected_values.delete();
            pending <= 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_values.size() == 0)
                begin
                    report_mismatch("response with no request waiting", rsp.random_value, '0);
                end
                else
                begin
                    oldest = expected_values.pop_front();
                    if (rsp.random_value !== oldest)
                    begin
                        report_mismatch("random_value", rsp.random_value, oldest);
                    end
                end
            end
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    xmr_pkg::REG_SHIFT_FIRST_LEFT:
                        settings.shift_first_left  = cfg.data[5:0];
                    xmr_pkg::REG_SHIFT_RIGHT:
                        settings.shift_right       = cfg.data[5:0];
                    xmr_pkg::REG_SHIFT_SECOND_LEFT:
                        settings.shift_second_left = cfg.data[5:0];
                    xmr_pkg::REG_MULTIPLIER:
                        settings.multiplier        = cfg.data;
                    xmr_pkg::REG_INCREMENT:
                        settings.increment         = cfg.data;
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
            begin
                gen_state = next_state(xmr_pkg::opcode_t'(req.opcode), req.seed_value,
                                       gen_state);
                expected_values.push_back(gen_state);
            end
            pending <= expected_values.size();
        end
    end

endmodule

// ===== test/tb_xorshift_mlcg_random_generator.sv =====
// Top of the generator testbench: clock, reset, request and register stimulus, verdict.
`timescale 1ns / 1ps

module tb_xorshift_mlcg_random_generator;

    localparam logic [2:0]  REG_SPARE_FIRST = xmr_pkg::REG_INCREMENT + 3'd1;
    localparam logic [2:0]  REG_SPARE_LAST  = '1;
    localparam logic [63:0] ALL_ONES        = '1;
    localparam int          PHASE_ITEMS     = 100;

    logic clk;
    logic rst_n;
    int   failures;
    int   pending;
    int   send_idle_pct;
    int   stall_pct;

    xmr_req_if req();
    xmr_rsp_if rsp();
    xmr_cfg_if cfg();

    xorshift_mlcg_random_generator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp),
        .cfg   (cfg)
    );

    xmr_scoreboard state_check (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req),
        .rsp      (rsp),
        .cfg      (cfg),
        .failures (failures),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("FAIL xorshift_mlcg_random_generator");
        $finish;
    end

    initial
    begin
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            rsp.ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_seed();
        logic [63:0] v;
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = ALL_ONES;
            default: v = rand64();
        endcase
        return v;
    endfunction

    task automatic wait_drained();
        req.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic send_request(input xmr_pkg::opcode_t op, input logic [63:0] seed);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.opcode     <= op;
        req.seed_value <= seed;
        do @(posedge clk); while (!req.ready);
    endtask

    task automatic put_register(input logic [2:0] idx, input logic [63:0] data);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic write_settings(input logic [5:0] first_left, input logic [5:0] right,
                                  input logic [5:0] second_left, input logic [63:0] mult,
                                  input logic [63:0] inc);
        logic [63:0] noise;
        wait_drained();
        noise = rand64();
        put_register(xmr_pkg::REG_SHIFT_FIRST_LEFT, {noise[63:6], first_left});
        noise = rand64();
        put_register(xmr_pkg::REG_SHIFT_RIGHT, {noise[63:6], right});
        noise = rand64();
        put_register(xmr_pkg::REG_SHIFT_SECOND_LEFT, {noise[63:6], second_left});
        put_register(xmr_pkg::REG_MULTIPLIER, mult);
        put_register(xmr_pkg::REG_INCREMENT, inc);
        put_register(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), rand64());
        cfg.valid <= 1'b0;
    endtask

    initial
    begin
        rst_n          <= 1'b0;
        req.valid      <= 1'b0;
        req.opcode     <= xmr_pkg::OP_LOAD;
        req.seed_value <= '0;
        cfg.valid      <= 1'b0;
        cfg.index      <= xmr_pkg::REG_SHIFT_FIRST_LEFT;
        cfg.data       <= '0;
        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(xmr_pkg::OP_XORSHIFT, '0);
        send_request(xmr_pkg::OP_LCG, rand64());
        send_request(xmr_pkg::OP_BOTH, ALL_ONES);
        send_request(xmr_pkg::OP_LOAD, '0);
        send_request(xmr_pkg::OP_XORSHIFT, ALL_ONES);
        send_request(xmr_pkg::OP_LCG, '0);
        send_request(xmr_pkg::OP_BOTH, rand64());
        send_request(xmr_pkg::OP_LOAD, ALL_ONES);
        send_request(xmr_pkg::OP_LCG, '0);
        send_request(xmr_pkg::OP_XORSHIFT, ALL_ONES);
        send_request(xmr_pkg::OP_LOAD, 64'd1);
        send_request(xmr_pkg::OP_BOTH, '0);

        write_settings('1, '1, '1, 64'd1, ALL_ONES);
        send_request(xmr_pkg::OP_LOAD, '0);
        send_request(xmr_pkg::OP_LCG, rand64());
        send_request(xmr_pkg::OP_LOAD, ALL_ONES);
        send_request(xmr_pkg::OP_XORSHIFT, '0);
        send_request(xmr_pkg::OP_BOTH, rand64());

        write_settings('0, '0, '0, xmr_pkg::RESET_MULTIPLIER, rand64());
        send_request(xmr_pkg::OP_LOAD, rand64());
        send_request(xmr_pkg::OP_XORSHIFT, rand64());
        send_request(xmr_pkg::OP_BOTH, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    write_settings(xmr_pkg::RESET_SHIFT_FIRST_LEFT, xmr_pkg::RESET_SHIFT_RIGHT,
                                   xmr_pkg::RESET_SHIFT_SECOND_LEFT,
                                   xmr_pkg::RESET_MULTIPLIER, xmr_pkg::RESET_INCREMENT);
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    write_settings('1, '1, '1, ALL_ONES, ALL_ONES);
                    send_idle_pct = 57;
                    stall_pct     = 0;
                end
                2:
                begin
                    write_settings(6'($urandom_range(1, 63)), 6'($urandom_range(1, 63)),
                                   6'($urandom_range(1, 63)), rand64() | 64'd1, rand64());
                    send_idle_pct = 0;
                    stall_pct     = 57;
                end
                default:
                begin
                    write_settings(6'($urandom_range(1, 63)), 6'($urandom_range(1, 63)),
                                   6'($urandom_range(1, 63)), rand64(), rand64());
                    send_idle_pct = 18;
                    stall_pct     = 18;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2)
                begin
                    wait_drained();
                end
                send_request(xmr_pkg::opcode_t'($urandom_range(0, 3)), pick_seed());
            end
        end

        wait_drained();
        repeat (4) @(posedge clk);
        if (failures == 0)
        begin
            $display("PASS xorshift_mlcg_random_generator");
        end
        else
        begin
            $display("FAIL xorshift_mlcg_random_generator");
        end
        $finish;
    end

endmodule
